// ===== sv/sord_pkg.sv =====
package sord_pkg;

    // Sweep geometry and object cap
    localparam int SCAN_LEN    = 90;
    localparam int MAX_OBJECTS = 5;

    // Field widths
    localparam int SAMPLE_W = 16;
    localparam int IDX_W    = 7;
    localparam int OBJ_W    = 3;
    localparam int ANGLE_W  = 8;
    localparam int COUNT_W  = 7;
    localparam int OCNT_W   = $clog2(MAX_OBJECTS + 1);

    // Result queue depth
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_NEAR_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_POINTS = 2'd2;

    // Configuration reset values
    localparam logic [SAMPLE_W-1:0] NEAR_LIMIT_RST = 16'd600;
    localparam logic [SAMPLE_W-1:0] TOLERANCE_RST  = 16'd40;
    localparam logic [COUNT_W-1:0]  MIN_POINTS_RST = 7'd4;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample_mm;
        logic                scan_start;
    } in_word_t;

    typedef struct packed {
        logic [OBJ_W-1:0]   object_number;
        logic [IDX_W-1:0]   start_index;
        logic [IDX_W-1:0]   finish_index;
        logic [IDX_W-1:0]   width;
        logic [ANGLE_W-1:0] center_angle;
    } out_word_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] near_limit;
        logic [SAMPLE_W-1:0] tolerance;
        logic [COUNT_W-1:0]  min_points;
    } cfg_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

// ===== sv/sord_front.sv =====
module sord_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  sord_pkg::in_word_t in_word,
    input  sord_pkg::cfg_t     cfg,
    output logic               push,
    output sord_pkg::out_word_t push_word
);
    import sord_pkg::*;

    logic [SAMPLE_W-1:0] previous_sample_reg, previous_sample_next;
    logic [IDX_W-1:0]    sample_index_reg, sample_index_next;
    logic [IDX_W-1:0]    run_start_reg, run_start_next;
    logic                run_active_reg, run_active_next;
    logic [COUNT_W-1:0]  point_count_reg, point_count_next;
    logic [OCNT_W-1:0]   object_count_reg, object_count_next;

    logic [IDX_W-1:0]    idx;
    logic [IDX_W-1:0]    first;
    logic [SAMPLE_W-1:0] diff;
    logic                in_range;
    logic                emit;

    // Classify the sample against the previous one
    always_comb
    begin
        idx      = sample_index_reg + IDX_W'(1);
        first    = run_start_reg - IDX_W'(1);
        in_range = sample_index_reg < IDX_W'(SCAN_LEN - 1);
        diff     = (in_word.sample_mm >= previous_sample_reg)
                   ? in_word.sample_mm - previous_sample_reg
                   : previous_sample_reg - in_word.sample_mm;
        emit     = 1'b0;

        previous_sample_next = previous_sample_reg;
        sample_index_next    = sample_index_reg;
        run_start_next       = run_start_reg;
        run_active_next      = run_active_reg;
        point_count_next     = point_count_reg;
        object_count_next    = object_count_reg;

        if (in_word.scan_start)
        begin
            previous_sample_next = in_word.sample_mm;
            sample_index_next    = '0;
            run_start_next       = '0;
            run_active_next      = 1'b0;
            point_count_next     = '0;
            object_count_next    = '0;
        end
        else if (in_range)
        begin
            sample_index_next    = idx;
            previous_sample_next = in_word.sample_mm;
            if (in_word.sample_mm < cfg.near_limit && diff <= cfg.tolerance)
            begin
                // Open or extend the run
                if (!run_active_reg)
                begin
                    run_active_next = 1'b1;
                    run_start_next  = idx;
                end
                if (point_count_reg != {COUNT_W{1'b1}})
                begin
                    point_count_next = point_count_reg + COUNT_W'(1);
                end
            end
            else
            begin
                // Close the run; a near break of a long run emits an object
                if (in_word.sample_mm < cfg.near_limit && run_active_reg &&
                    point_count_reg >= cfg.min_points &&
                    object_count_reg < OCNT_W'(MAX_OBJECTS))
                begin
                    emit              = 1'b1;
                    object_count_next = object_count_reg + OCNT_W'(1);
                end
                run_active_next  = 1'b0;
                point_count_next = COUNT_W'(1);
            end
        end
    end

    // Build the object word
    always_comb
    begin
        push                    = accept && emit;
        push_word.object_number = OBJ_W'(object_count_reg);
        push_word.start_index   = first;
        push_word.finish_index  = idx;
        push_word.width         = idx - first;
        push_word.center_angle  = ANGLE_W'(idx) + ANGLE_W'(first);
    end

    // Advance sweep state on each accepted word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            previous_sample_reg <= '0;
            sample_index_reg    <= '0;
            run_start_reg       <= '0;
            run_active_reg      <= 1'b0;
            point_count_reg     <= '0;
            object_count_reg    <= '0;
        end
        else if (accept)
        begin
            previous_sample_reg <= previous_sample_next;
            sample_index_reg    <= sample_index_next;
            run_start_reg       <= run_start_next;
            run_active_reg      <= run_active_next;
            point_count_reg     <= point_count_next;
            object_count_reg    <= object_count_next;
        end
    end

endmodule

// ===== sv/sord_queue.sv =====
module sord_queue (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  sord_pkg::out_word_t     push_word,
    input  logic                    pop,
    output sord_pkg::out_word_t     head_word,
    output sord_pkg::queue_status_t status
);
    import sord_pkg::*;

    out_word_t         mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg, count_next;

    // Report fill state
    always_comb
    begin
        status.full  = count_reg == QCNT_W'(QUEUE_DEPTH);
        status.empty = count_reg == '0;
        head_word    = mem[rd_ptr_reg];
        count_next   = count_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    // Store pushed words
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_word;
        end
    end

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1))
                              ? '0 : wr_ptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1))
                              ? '0 : rd_ptr_reg + QPTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

endmodule

// ===== sv/scan_run_object_detector.sv =====
// Near-object detector over one sweep of distance samples.
// Input channel (in_valid / in_stall / in_word): one distance sample per
// word; scan_start marks sample index 0 of a sweep and clears the run and
// object count. A word is taken at an edge with in_valid high and in_stall low.
// Output channel (out_valid / out_stall / out_word): one object word when a
// run of near, neighboring samples breaks with enough points.
// Configuration channel (cfg_valid / cfg_ready / cfg_index / cfg_data):
// index 0 near_limit, 1 tolerance, 2 min_points; cfg_ready is always high.
// Throughput: one sample per cycle while in_stall is low. The front classifier
// updates the sweep state in the cycle of acceptance and pushes any object into
// a four-word queue; an empty queue raises out_valid in the next cycle.
// When the receiver holds out_stall, objects collect in the queue; in_stall
// rises only while the queue holds four words, and drops as soon as one is
// taken. Samples that produce no object still need a free queue slot only
// when the queue is full.
// Reset clears the sweep state, empties the queue and loads the default
// configuration (near_limit 600, tolerance 40, min_points 4).
module scan_run_object_detector (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  sord_pkg::in_word_t                 in_word,
    output logic                               out_valid,
    input  logic                               out_stall,
    output sord_pkg::out_word_t                out_word,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [sord_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sord_pkg::SAMPLE_W-1:0]      cfg_data
);
    import sord_pkg::*;

    cfg_t          cfg_reg;
    queue_status_t qstat;
    logic          in_accept;
    logic          push;
    out_word_t     push_word;
    logic          pop;

    // Handshakes
    assign cfg_ready = 1'b1;
    assign in_stall  = qstat.full;
    assign in_accept = in_valid && !qstat.full;
    assign out_valid = !qstat.empty;
    assign pop       = out_valid && !out_stall;

    // Hold configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.near_limit <= NEAR_LIMIT_RST;
            cfg_reg.tolerance  <= TOLERANCE_RST;
            cfg_reg.min_points <= MIN_POINTS_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_NEAR_LIMIT: cfg_reg.near_limit <= cfg_data;
                REG_TOLERANCE:  cfg_reg.tolerance  <= cfg_data;
                REG_MIN_POINTS: cfg_reg.min_points <= cfg_data[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    sord_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (in_accept),
        .in_word   (in_word),
        .cfg       (cfg_reg),
        .push      (push),
        .push_word (push_word)
    );

    sord_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_word (push_word),
        .pop       (pop),
        .head_word (out_word),
        .status    (qstat)
    );

`ifndef SYNTHESIS
    // A full queue always has a word to offer
    a_full_has_word: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("queue full without a word to deliver");

    // Center angle is finish plus start
    a_center_sum: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_word.center_angle ==
            ANGLE_W'(out_word.finish_index) + ANGLE_W'(out_word.start_index))
        else $error("center angle mismatch");

    // Object numbers stay below the cap
    a_object_cap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_word.object_number < OBJ_W'(MAX_OBJECTS))
        else $error("object number beyond cap");

    // A sweep start word never produces an object
    a_start_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && in_word.scan_start) |-> !push)
        else $error("object pushed on sweep start");
`endif

endmodule

// ===== tb/scan_run_object_detector_test.sv =====
`timescale 1ns / 1ps

module scan_run_object_detector_test;
    import sord_pkg::*;

    localparam int CYCLE_LIMIT   = 500000;
    localparam int SETTLE_CYCLES = 4;
    localparam int TAIL_CYCLES   = 8;
    localparam int LONG_HOLD     = 250;

    // Index past the last register; writes to it change nothing
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;

    typedef struct packed {
        row_kind_t           kind;
        logic                start;
        logic [SAMPLE_W-1:0] value;
        logic [CFG_IDX_W-1:0] reg_sel;
        logic                typed;
        out_word_t           want;
    } plan_row_t;

    localparam int PLAN_LEN = 29;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    in_word_t             in_word;
    logic                 out_valid;
    logic                 out_stall;
    out_word_t            out_word;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [SAMPLE_W-1:0]  cfg_data;

    // Shadow of the detector configuration
    logic [SAMPLE_W-1:0] near_mm;
    logic [SAMPLE_W-1:0] tol_mm;
    logic [COUNT_W-1:0]  min_pts;

    // Shadow of the sweep state
    logic [SAMPLE_W-1:0] prev_mm;
    logic [IDX_W-1:0]    cur_idx;
    logic [IDX_W-1:0]    run_first;
    logic                run_open;
    logic [COUNT_W-1:0]  points;
    logic [OBJ_W-1:0]    objects;
    logic                step_ignored;

    out_word_t objects_due[$];

    int  mismatch_count = 0;
    int  cycle_count = 0;
    int  hold_seq = 0;
    bit  calm_tail = 1'b0;
    int  sweep_left = 0;
    int  walk_mm = 0;

    // Directed sweep: reset defaults first, then an object cap run
    plan_row_t plan [0:PLAN_LEN-1] = '{
        '{ROW_SAMPLE, 1'b0, 16'd0,     REG_NEAR_LIMIT, 1'b0, '0},
        '{ROW_SAMPLE, 1'b1, 16'd100,   REG_NEAR_LIMIT, 1'b0, '0},
        '{ROW_SAMPLE, 1'b0, 16'd100,   REG_NEAR_LIMIT, 1'b0, '0},
        '{ROW_SAMPLE, 1'b0, 16'd100,   REG_NEAR_LIMIT, 1'b0, '0},
        '{ROW_SAMPLE, 1'b0, 16'd120,   REG_NEAR_LIMIT, 1'b0, '0},
        '{ROW_SAMPLE, 1'b0, 16'd140,   REG_NEAR_LIMIT, 1'b0, '0},
        '{ROW_SAMPLE, 1'b0, 16'd500,   REG_NEAR_LIMIT, 1'b1,
          '{3'd0, 7'd0, 7'd5, 7'd5, 8'd5}},
        '{ROW_SAMPLE, 1'b0, 16'd599,   REG_NEAR_LIMIT, 1'b0, '0},
        '{ROW_SAMPLE, 1'b0, 16'd600,   REG_NEAR_LIMIT, 1'b0, '0},
        '{ROW_SAMPLE, 1'b0, 16'd65535, REG_NEAR_LIMIT, 1'b0, '0},
        '{ROW_SAMPLE, 1'b0, 16'd0,     REG_NEAR_LIMIT, 1'b0, '0},
        '{ROW_WRITE,  1'b0, 16'd65535, REG_NEAR_LIMIT, 1'b0, '0},
        '{ROW_WRITE,  1'b0, 16'd0,     REG_TOLERANCE,  1'b0, '0},
        '{ROW_WRITE,  1'b0, 16'd0,     REG_MIN_POINTS, 1'b0, '0},
        '{ROW_WRITE,  1'b0, 16'hFFFF,  REG_SPARE,      1'b0, '0},
        '{ROW_SAMPLE, 1'b1, 16'd1000,  REG_NEAR_LIMIT, 1'b0, '0},
        '{ROW_SAMPLE, 1'b0, 16'd1000,  REG_NEAR_LIMIT, 1'b0, '0},
        '{ROW_SAMPLE, 1'b0, 16'd2000,  REG_NEAR_LIMIT, 1'b1,
          '{3'd0, 7'd0, 7'd2, 7'd2, 8'd2}},
        '{ROW_SAMPLE, 1'b0, 16'd2000,  REG_NEAR_LIMIT, 1'b0, '0},
        '{ROW_SAMPLE, 1'b0, 16'd1000,  REG_NEAR_LIMIT, 1'b0, '0},
        '{ROW_SAMPLE, 1'b0, 16'd1000,  REG_NEAR_LIMIT, 1'b0, '0},
        '{ROW_SAMPLE, 1'b0, 16'd2000,  REG_NEAR_LIMIT, 1'b0, '0},
        '{ROW_SAMPLE, 1'b0, 16'd2000,  REG_NEAR_LIMIT, 1'b0, '0},
        '{ROW_SAMPLE, 1'b0, 16'd1000,  REG_NEAR_LIMIT, 1'b0, '0},
        '{ROW_SAMPLE, 1'b0, 16'd1000,  REG_NEAR_LIMIT, 1'b0, '0},
        '{ROW_SAMPLE, 1'b0, 16'd2000,  REG_NEAR_LIMIT, 1'b0, '0},
        '{ROW_SAMPLE, 1'b0, 16'd2000,  REG_NEAR_LIMIT, 1'b0, '0},
        '{ROW_SAMPLE, 1'b0, 16'd1000,  REG_NEAR_LIMIT, 1'b0, '0},
        '{ROW_SAMPLE, 1'b0, 16'd65535, REG_NEAR_LIMIT, 1'b0, '0}
    };

    scan_run_object_detector uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #6 clk = ~clk;

    // Count cycles and stop a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic note_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        $display("mismatch %s: got %0d want %0d (cycle %0d)", what, got, want,
                 cycle_count);
    endtask

    // Advance the shadow sweep by one sample; return 1 when an object is emitted
    function automatic bit detect_step(input in_word_t w, output out_word_t obj);
        logic [SAMPLE_W-1:0] diff;
        int idx;
        int first;
        bit found;
        obj = '0;
        found = 1'b0;
        step_ignored = 1'b0;
        if (w.scan_start)
        begin
            prev_mm   = w.sample_mm;
            cur_idx   = '0;
            run_first = '0;
            run_open  = 1'b0;
            points    = '0;
            objects   = '0;
        end
        else if (int'(cur_idx) + 1 >= SCAN_LEN)
        begin
            // drop samples past the end of the sweep
            step_ignored = 1'b1;
        end
        else
        begin
            idx = int'(cur_idx) + 1;
            cur_idx = IDX_W'(idx);
            diff = (w.sample_mm >= prev_mm) ? w.sample_mm - prev_mm
                                            : prev_mm - w.sample_mm;
            if (w.sample_mm < near_mm && diff <= tol_mm)
            begin
                // open or extend the run
                if (!run_open)
                begin
                    run_open  = 1'b1;
                    run_first = cur_idx;
                end
                if (points < 7'd127)
                    points = points + 7'd1;
            end
            else
            begin
                // a near break may emit, a far sample never does
                if (w.sample_mm < near_mm && run_open && points >= min_pts &&
                    int'(objects) < MAX_OBJECTS)
                begin
                    first = int'(run_first) - 1;
                    obj.object_number = objects;
                    obj.start_index   = IDX_W'(first);
                    obj.finish_index  = IDX_W'(idx);
                    obj.width         = IDX_W'(idx - first);
                    obj.center_angle  = ANGLE_W'(idx + first);
                    objects = objects + 3'd1;
                    found = 1'b1;
                end
                run_open = 1'b0;
                points   = 7'd1;
            end
            prev_mm = w.sample_mm;
        end
        return found;
    endfunction

    // Offer one word, hold it until taken, then queue what it should produce
    task automatic send_word(input in_word_t w, input bit typed, input out_word_t want);
        out_word_t obj;
        bit hit;
        if (!calm_tail && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        hit = detect_step(w, obj);
        if (typed)
            objects_due.push_back(want);
        else if (hit)
            objects_due.push_back(obj);
        @(negedge clk);
    endtask

    // Stop sending and wait until every object is out and the pipe is quiet
    task automatic idle_settle();
        in_valid <= 1'b0;
        while (objects_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Write one register; leaves cfg_valid high for a following write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [SAMPLE_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_NEAR_LIMIT: near_mm = data;
            REG_TOLERANCE:  tol_mm  = data;
            REG_MIN_POINTS: min_pts = data[COUNT_W-1:0];
            default: ;
        endcase
        @(negedge clk);
    endtask

    task automatic set_config(input logic [SAMPLE_W-1:0] near_val,
                              input logic [SAMPLE_W-1:0] tol_val,
                              input logic [SAMPLE_W-1:0] min_val);
        idle_settle();
        write_reg(REG_NEAR_LIMIT, near_val);
        write_reg(REG_TOLERANCE, tol_val);
        write_reg(REG_MIN_POINTS, min_val);
        cfg_valid <= 1'b0;
    endtask

    // Random sweeps: mostly slow walks below the near limit, with breaks,
    // far samples, overlong sweeps and stray sweep starts mixed in
    task automatic feed_samples(input int count);
        in_word_t w;
        int taken;
        int pick;
        int d;
        int v;
        int near_i;
        int tol_i;
        bit up;
        taken = 0;
        while (taken < count)
        begin
            near_i = near_mm;
            tol_i  = tol_mm;
            if (sweep_left <= 0)
            begin
                pick = $urandom_range(0, 9);
                if (pick < 6)
                    sweep_left = SCAN_LEN - 1;
                else if (pick < 8)
                    sweep_left = $urandom_range(10, SCAN_LEN - 2);
                else
                    sweep_left = $urandom_range(SCAN_LEN, SCAN_LEN + 20);
                w.scan_start = 1'b1;
                walk_mm = (near_i != 0) ? $urandom_range(0, near_i - 1)
                                        : $urandom_range(0, 65535);
            end
            else
            begin
                sweep_left--;
                w.scan_start = ($urandom_range(0, 149) == 0);
                pick = $urandom_range(0, 99);
                if (near_i == 0 || pick >= 98)
                    walk_mm = $urandom_range(0, 65535);
                else if (pick < 86)
                begin
                    // step inside the band, on its edge, or just past it
                    if (pick < 80)
                        d = ($urandom_range(0, 3) == 0) ? tol_i : $urandom_range(0, tol_i);
                    else
                        d = tol_i + 1;
                    up = $urandom_range(0, 1);
                    v = up ? walk_mm + d : walk_mm - d;
                    if (v < 0 || v >= near_i)
                        v = up ? walk_mm - d : walk_mm + d;
                    if (v < 0)
                        v = 0;
                    if (v >= near_i)
                        v = near_i - 1;
                    walk_mm = v;
                end
                else if (pick < 92)
                    walk_mm = $urandom_range(0, near_i - 1);
                else
                    walk_mm = $urandom_range(near_i, 65535);
            end
            w.sample_mm = walk_mm[SAMPLE_W-1:0];
            send_word(w, 1'b0, '0);
            if (!step_ignored)
                taken++;
        end
    endtask

    // Check each taken object word against the oldest expected one
    always @(posedge clk)
    begin : monitor
        out_word_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (objects_due.size() == 0)
                note_mismatch("object word with none due", out_word.finish_index, 0);
            else
            begin
                want = objects_due.pop_front();
                if (out_word.object_number !== want.object_number)
                    note_mismatch("object_number", out_word.object_number,
                                  want.object_number);
                if (out_word.start_index !== want.start_index)
                    note_mismatch("start_index", out_word.start_index, want.start_index);
                if (out_word.finish_index !== want.finish_index)
                    note_mismatch("finish_index", out_word.finish_index,
                                  want.finish_index);
                if (out_word.width !== want.width)
                    note_mismatch("width", out_word.width, want.width);
                if (out_word.center_angle !== want.center_angle)
                    note_mismatch("center_angle", out_word.center_angle,
                                  want.center_angle);
            end
        end
    end

    // Receiver: random stall bursts, plus one long hold when requested
    initial
    begin : receiver
        int hold_seen;
        hold_seen = 0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_seq != hold_seen)
            begin
                out_stall <= 1'b1;
                repeat (LONG_HOLD - 1) @(negedge clk);
                hold_seen = hold_seq;
            end
            else if (!calm_tail && $urandom_range(0, 7) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(0, 9)) @(negedge clk);
            end
            else
                out_stall <= 1'b0;
        end
    end

    initial
    begin : stimulus
        in_word_t w;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_word   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;

        near_mm   = NEAR_LIMIT_RST;
        tol_mm    = TOLERANCE_RST;
        min_pts   = MIN_POINTS_RST;
        prev_mm   = '0;
        cur_idx   = '0;
        run_first = '0;
        run_open  = 1'b0;
        points    = '0;
        objects   = '0;
        step_ignored = 1'b0;

        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Walk the directed table
        for (int i = 0; i < PLAN_LEN; i++)
        begin
            if (plan[i].kind == ROW_WRITE)
            begin
                idle_settle();
                write_reg(plan[i].reg_sel, plan[i].value);
                cfg_valid <= 1'b0;
            end
            else
            begin
                w.sample_mm  = plan[i].value;
                w.scan_start = plan[i].start;
                send_word(w, plan[i].typed, plan[i].want);
            end
        end

        // Random phases over a spread of settings
        set_config(16'd2000, 16'd50, 16'd3);
        feed_samples(250);

        // Long receiver hold while samples keep coming, then a full drain
        set_config(NEAR_LIMIT_RST, TOLERANCE_RST, 16'(MIN_POINTS_RST));
        hold_seq++;
        feed_samples(200);
        idle_settle();
        feed_samples(150);

        set_config(16'd0, 16'd40, 16'd4);
        feed_samples(100);

        set_config(16'd1500, 16'd0, 16'd2);
        feed_samples(200);

        set_config(16'd800, 16'd65535, 16'd127);
        feed_samples(150);

        set_config(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 3000)),
                   16'($urandom_range(0, 65535)));
        feed_samples(200);

        set_config(16'd65535, 16'd300, 16'd1);
        feed_samples(200);

        // Closing stretch with no idling on either side
        calm_tail = 1'b1;
        set_config(16'd3000, 16'd150, 16'd5);
        feed_samples(200);

        idle_settle();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (objects_due.size() != 0)
            note_mismatch("objects never delivered", 0, objects_due.size());

        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
